@@ sv/hsv2rgb_pkg.sv @@
// Shared constants, types and helpers for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int HUE_W        = 9;
	localparam int FRAC_W       = 8;
	localparam int REM_W        = 6;
	localparam int K_W          = 14;
	localparam int PROD_W       = K_W + FRAC_W;
	localparam int RECIP_W      = 11;
	localparam int EST_W        = PROD_W + RECIP_W;
	localparam int RECIP_SHIFT  = 24;

	localparam logic [HUE_W-1:0]  HUE_MAX    = 9'd359;
	localparam logic [REM_W-1:0]  SECTOR_DEG = 6'd60;
	localparam logic [K_W-1:0]    K_ONE      = 14'd15300;
	// floor(2^24 / 15300): estimate is low by at most one
	localparam logic [RECIP_W-1:0] RECIP     = 11'd1096;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [K_W-1:0]          kfac_t;
	typedef logic [PROD_W-1:0]       prod_t;

	typedef enum logic [2:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4,
		SECT_MAG_RED = 3'd5
	} sector_t;

	// start of a sector in degrees
	function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
		logic [HUE_W-1:0] base;
		unique case (sec)
			SECT_RED_YEL: base = 9'd0;
			SECT_YEL_GRN: base = 9'd60;
			SECT_GRN_CYN: base = 9'd120;
			SECT_CYN_BLU: base = 9'd180;
			SECT_BLU_MAG: base = 9'd240;
			default:      base = 9'd300;
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

@@ sv/hsv2rgb_in_if.sv @@
// Input channel: one HSV pixel per beat.
`timescale 1ns / 1ps
`default_nettype none

interface hsv2rgb_in_if;
	logic                           valid;
	logic                           ready;
	logic [hsv2rgb_pkg::HUE_W-1:0]  hue_deg;
	logic [hsv2rgb_pkg::FRAC_W-1:0] saturation;
	logic [hsv2rgb_pkg::FRAC_W-1:0] brightness;

	modport source (output valid, output hue_deg, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue_deg, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

@@ sv/hsv2rgb_out_if.sv @@
// Output channel: one RGB pixel per beat.
`timescale 1ns / 1ps
`default_nettype none

interface hsv2rgb_out_if;
	logic                 valid;
	logic                 ready;
	hsv2rgb_pkg::chan_t   red;
	hsv2rgb_pkg::chan_t   green;
	hsv2rgb_pkg::chan_t   blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ sv/hsv2rgb_div.sv @@
// Divide-by-15300 unit for three channels: reciprocal estimate, then one correction.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_div (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire hsv2rgb_pkg::prod_t num [3],
	output hsv2rgb_pkg::chan_t      quo [3]
);
	import hsv2rgb_pkg::*;

	logic [EST_W-1:0] est [3];
	chan_t            q0_s4 [3];
	prod_t            num_s4 [3];
	prod_t            rem [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			est[i] = EST_W'(num[i]) * EST_W'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				q0_s4[i]  <= est[i][RECIP_SHIFT +: CHANNEL_BITS];
				num_s4[i] <= num[i];
			end
		end
	end

	// bump the estimate when the remainder still holds a whole divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem[i] = num_s4[i] - PROD_W'(q0_s4[i]) * PROD_W'(K_ONE);
			quo[i] = (rem[i] >= PROD_W'(K_ONE)) ? q0_s4[i] + chan_t'(1) : q0_s4[i];
		end
	end

endmodule

`default_nettype wire

@@ sv/hsv_to_rgb_converter_top.sv @@
// Top level of the pipelined HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one HSV pixel per clock, while the output side keeps ready high, into
// 8-bit red, green and blue. Hue is in whole degrees and clamps to 359;
// saturation and brightness are fractions over 255. The pipeline has five
// register stages (hue split, sector factors, brightness products, reciprocal
// estimate, correction and channel select). Back-pressure stalls only the
// stages that are full, and any empty stage lets a new input beat in.
module hsv_to_rgb_converter_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hsv2rgb_in_if.sink    hsv,
	hsv2rgb_out_if.source rgb
);
	import hsv2rgb_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	// stage 1
	logic [HUE_W-1:0] hue_c;
	sector_t          sec_c;
	logic [HUE_W-1:0] f_full;
	sector_t          sec_s1;
	logic [REM_W-1:0] f_s1;
	logic [FRAC_W-1:0] sat_s1, v_s1;
	// stage 2
	sector_t          sec_s2;
	logic [FRAC_W-1:0] v_s2;
	kfac_t            kp_s2, kq_s2, kt_s2;
	// stage 3
	sector_t          sec_s3;
	logic [FRAC_W-1:0] v_s3;
	prod_t            prod_s3 [3];
	// stage 4
	sector_t          sec_s4;
	logic [FRAC_W-1:0] v_s4;
	chan_t            quo [3];
	// stage 5
	chan_t            red_s5, green_s5, blue_s5;

	assign en5 = !vld_s5 || rgb.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign hsv.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= hsv.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// clamp the hue and split it into sector and remainder
	always_comb begin
		hue_c = (hsv.hue_deg > HUE_MAX) ? HUE_MAX : hsv.hue_deg;
		priority if (hue_c < 9'd60)  sec_c = SECT_RED_YEL;
		else if (hue_c < 9'd120)     sec_c = SECT_YEL_GRN;
		else if (hue_c < 9'd180)     sec_c = SECT_GRN_CYN;
		else if (hue_c < 9'd240)     sec_c = SECT_CYN_BLU;
		else if (hue_c < 9'd300)     sec_c = SECT_BLU_MAG;
		else                         sec_c = SECT_MAG_RED;
		f_full = hue_c - sector_base(sec_c);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sec_s1 <= sec_c;
			f_s1   <= f_full[REM_W-1:0];
			sat_s1 <= hsv.saturation;
			v_s1   <= hsv.brightness;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sec_s2 <= sec_s1;
			v_s2   <= v_s1;
			kp_s2  <= K_ONE - K_W'(sat_s1) * K_W'(SECTOR_DEG);
			kq_s2  <= K_ONE - K_W'(sat_s1) * K_W'(f_s1);
			kt_s2  <= K_ONE - K_W'(sat_s1) * K_W'(SECTOR_DEG - f_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sec_s3     <= sec_s2;
			v_s3       <= v_s2;
			prod_s3[0] <= PROD_W'(v_s2) * PROD_W'(kp_s2);
			prod_s3[1] <= PROD_W'(v_s2) * PROD_W'(kq_s2);
			prod_s3[2] <= PROD_W'(v_s2) * PROD_W'(kt_s2);
		end
	end

	hsv2rgb_div u_div (
		.clk (clk),
		.en  (en4),
		.num (prod_s3),
		.quo (quo)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			sec_s4 <= sec_s3;
			v_s4   <= v_s3;
		end
	end

	// quo[0] = p, quo[1] = q, quo[2] = t
	always_ff @(posedge clk) begin
		if (en5) begin
			unique case (sec_s4)
				SECT_RED_YEL: begin
					red_s5 <= v_s4;    green_s5 <= quo[2]; blue_s5 <= quo[0];
				end
				SECT_YEL_GRN: begin
					red_s5 <= quo[1];  green_s5 <= v_s4;   blue_s5 <= quo[0];
				end
				SECT_GRN_CYN: begin
					red_s5 <= quo[0];  green_s5 <= v_s4;   blue_s5 <= quo[2];
				end
				SECT_CYN_BLU: begin
					red_s5 <= quo[0];  green_s5 <= quo[1]; blue_s5 <= v_s4;
				end
				SECT_BLU_MAG: begin
					red_s5 <= quo[2];  green_s5 <= quo[0]; blue_s5 <= v_s4;
				end
				default: begin
					red_s5 <= v_s4;    green_s5 <= quo[0]; blue_s5 <= quo[1];
				end
			endcase
		end
	end

	assign rgb.valid = vld_s5;
	assign rgb.red   = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue  = blue_s5;

	// any empty stage must open the input
	a_ready_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.ready == (!vld_s1 || !vld_s2 || !vld_s3 || !vld_s4 || !vld_s5 || rgb.ready))
		else $error("input ready disagrees with pipeline occupancy");

	// beats in minus beats out track the pipeline fill
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (3'(vld_s1) + 3'(vld_s2) + 3'(vld_s3) + 3'(vld_s4) + 3'(vld_s5))
			== (3'($past(vld_s1)) + 3'($past(vld_s2)) + 3'($past(vld_s3))
			+ 3'($past(vld_s4)) + 3'($past(vld_s5))
			+ 3'($past(hsv.valid && hsv.ready)) - 3'($past(rgb.valid && rgb.ready))))
		else $error("pipeline lost or repeated a beat");

	a_hue_split: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (f_s1 < SECTOR_DEG) && (sec_s1 <= SECT_MAG_RED))
		else $error("hue split out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !rgb.ready |=> vld_s5 && $stable(red_s5) && $stable(green_s5)
			&& $stable(blue_s5))
		else $error("output stage changed under stall");

endmodule

`default_nettype wire

@@ tb/sv/hsv2rgb_checker.sv @@
// Scoreboard for the HSV to RGB converter: predicts each pixel and compares it.
`timescale 1ns / 1ps

module hsv2rgb_checker (
	input  logic   clk,
	input  logic   arst_n,
	hsv2rgb_in_if  hsv,
	hsv2rgb_out_if rgb,
	output int     fail_count,
	output int     pixels_in,
	output int     pixels_out
);
	import hsv2rgb_pkg::*;

	localparam int unsigned FULL_FRAC = 255;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_rgb_t;

	pixel_rgb_t rgb_due[$];

	// floor(v * k * cmax / (255 * 15300)), k over 15300
	function automatic chan_t chan_scale(input int unsigned v, input int unsigned k);
		longint unsigned cmax;
		longint unsigned num;
		cmax = (longint'(1) << CHANNEL_BITS) - 1;
		num = longint'(v) * longint'(k) * cmax;
		return chan_t'(num / (longint'(FULL_FRAC) * longint'(K_ONE)));
	endfunction

	function automatic pixel_rgb_t predict_pixel(input logic [HUE_W-1:0] hue,
			input logic [FRAC_W-1:0] sat, input logic [FRAC_W-1:0] val);
		logic [HUE_W-1:0] h;
		int unsigned      f;
		int unsigned      s;
		int unsigned      v;
		int unsigned      kone;
		int unsigned      deg;
		sector_t          sec;
		chan_t            cv, cp, cq, ct;
		pixel_rgb_t       px;
		h    = (hue > HUE_MAX) ? HUE_MAX : hue;
		kone = 32'(K_ONE);
		deg  = 32'(SECTOR_DEG);
		sec  = sector_t'(32'(h) / deg);
		f    = 32'(h) % deg;
		s    = 32'(sat);
		v    = 32'(val);
		cv   = chan_scale(v, kone);
		cp   = chan_scale(v, kone - s * deg);
		cq   = chan_scale(v, kone - s * f);
		ct   = chan_scale(v, kone - s * (deg - f));
		case (sec)
			SECT_RED_YEL: px = '{cv, ct, cp};
			SECT_YEL_GRN: px = '{cq, cv, cp};
			SECT_GRN_CYN: px = '{cp, cv, ct};
			SECT_CYN_BLU: px = '{cp, cq, cv};
			SECT_BLU_MAG: px = '{ct, cp, cv};
			default:      px = '{cv, cp, cq};
		endcase
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_rgb_t want;
		int         bad;
		if (!arst_n) begin
			rgb_due.delete();
			fail_count <= 0;
			pixels_in  <= 0;
			pixels_out <= 0;
		end else begin
			bad = 0;
			// retire the oldest expectation before queueing this cycle's input beat
			if (rgb.valid && rgb.ready) begin
				pixels_out <= pixels_out + 1;
				if (rgb_due.size() == 0) begin
					$error("rgb beat with no pixel outstanding: %0d %0d %0d",
						rgb.red, rgb.green, rgb.blue);
					bad++;
				end else begin
					want = rgb_due.pop_front();
					if (rgb.red !== want.red) begin
						$error("red mismatch: expected %0d, got %0d", want.red, rgb.red);
						bad++;
					end
					if (rgb.green !== want.green) begin
						$error("green mismatch: expected %0d, got %0d", want.green, rgb.green);
						bad++;
					end
					if (rgb.blue !== want.blue) begin
						$error("blue mismatch: expected %0d, got %0d", want.blue, rgb.blue);
						bad++;
					end
				end
			end
			if (hsv.valid && hsv.ready) begin
				rgb_due.push_back(predict_pixel(hsv.hue_deg, hsv.saturation, hsv.brightness));
				pixels_in <= pixels_in + 1;
			end
			fail_count <= fail_count + bad;
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the HSV to RGB converter: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
	import hsv2rgb_pkg::*;

	localparam int PIPE_DEPTH   = 5;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_LIMIT   = 5000;
	localparam int PHASE_PIXELS = 300;

	logic clk;
	logic arst_n;
	logic hold_req;
	logic hold_done;
	int   src_idle_pct;
	int   snk_idle_pct;
	int   fail_count;
	int   pixels_in;
	int   pixels_out;
	int   clamped;
	int   greys;
	int   idle_cycles;

	hsv2rgb_in_if  hsv ();
	hsv2rgb_out_if rgb ();

	hsv_to_rgb_converter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv),
		.rgb    (rgb)
	);

	hsv2rgb_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv        (hsv),
		.rgb        (rgb),
		.fail_count (fail_count),
		.pixels_in  (pixels_in),
		.pixels_out (pixels_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// offer one pixel after a random gap and hold it until accepted
	task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [FRAC_W-1:0] s,
			input logic [FRAC_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			hsv.valid <= 1'b0;
			@(posedge clk);
		end
		hsv.valid      <= 1'b1;
		hsv.hue_deg    <= h;
		hsv.saturation <= s;
		hsv.brightness <= v;
		@(posedge clk);
		while (!hsv.ready)
			@(posedge clk);
		if (h > HUE_MAX)
			clamped++;
		if (s == '0)
			greys++;
	endtask

	task automatic send_random_pixel();
		logic [HUE_W-1:0]  h;
		logic [FRAC_W-1:0] s;
		logic [FRAC_W-1:0] v;
		h = ($urandom_range(99) < 15) ? HUE_W'($urandom_range(511, 360))
			: HUE_W'($urandom_range(359, 0));
		case ($urandom_range(9))
			0:       s = '0;
			1:       s = '1;
			default: s = FRAC_W'($urandom_range(255));
		endcase
		case ($urandom_range(9))
			0:       v = '0;
			1:       v = '1;
			default: v = FRAC_W'($urandom_range(255));
		endcase
		send_pixel(h, s, v);
	endtask

	// stop offering and wait until every pixel sent has come back
	task automatic drain();
		hsv.valid <= 1'b0;
		@(posedge clk);
		while (pixels_in != pixels_out)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rgb.ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				rgb.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			rgb.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// watchdog: end the run if no beat moves for too long
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((hsv.valid && hsv.ready) || (rgb.valid && rgb.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		hsv.valid      = 1'b0;
		hsv.hue_deg    = '0;
		hsv.saturation = '0;
		hsv.brightness = '0;
		hold_req       = 1'b0;
		clamped        = 0;
		greys          = 0;
		arst_n         = 1'b0;
		src_idle_pct   = 10;
		snk_idle_pct   = 78;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sector edges at full saturation and brightness, grey, black, clamped hue
		send_pixel(9'd0,   8'd0,   8'd0);
		send_pixel(9'd0,   8'd255, 8'd255);
		send_pixel(9'd59,  8'd255, 8'd255);
		send_pixel(9'd60,  8'd255, 8'd255);
		send_pixel(9'd119, 8'd255, 8'd255);
		send_pixel(9'd120, 8'd255, 8'd255);
		send_pixel(9'd179, 8'd255, 8'd255);
		send_pixel(9'd180, 8'd255, 8'd255);
		send_pixel(9'd239, 8'd255, 8'd255);
		send_pixel(9'd240, 8'd255, 8'd255);
		send_pixel(9'd299, 8'd255, 8'd255);
		send_pixel(9'd300, 8'd255, 8'd255);
		send_pixel(9'd359, 8'd255, 8'd255);
		send_pixel(9'd360, 8'd255, 8'd255);
		send_pixel(9'd511, 8'd255, 8'd255);
		send_pixel(9'd256, 8'd128, 8'd200);
		send_pixel(9'd30,  8'd0,   8'd255);
		send_pixel(9'd200, 8'd0,   8'd77);
		send_pixel(9'd90,  8'd255, 8'd0);
		send_pixel(9'd45,  8'd1,   8'd255);
		send_pixel(9'd330, 8'd128, 8'd128);
		send_pixel(9'd15,  8'd255, 8'd1);
		send_pixel(9'd400, 8'd170, 8'd85);
		send_pixel(9'd210, 8'd85,  8'd170);

		repeat (PHASE_PIXELS) send_random_pixel();

		src_idle_pct = 78;
		snk_idle_pct = 10;
		repeat (PHASE_PIXELS / 2) send_random_pixel();
		drain();
		repeat (PHASE_PIXELS / 2) send_random_pixel();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		// fill the pipeline against a held-off receiver
		hold_req = 1'b1;
		repeat (PHASE_PIXELS) send_random_pixel();

		drain();
		repeat (PIPE_DEPTH * 4) @(posedge clk);

		$display("Checked %0d of %0d pixels across three stall phases and one long hold-off",
			pixels_out, pixels_in);
		$display("Clamped hues: %0d, zero-saturation pixels: %0d", clamped, greys);
		if (fail_count == 0 && pixels_in == pixels_out) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
